[sv/rpnp_pkg.sv]
// rpnp_pkg: types, character codes and the per-byte parse step of the number parser
// used by rpnp_core and radix_prefix_number_parser; no dependencies
`timescale 1ns / 1ps

package rpnp_pkg;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_HEX  = 2'd2
    } t_mode;

    localparam int unsigned ModeW  = 2;
    localparam int unsigned ValueW = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] ALPHA_OFS = 8'd55;
    localparam logic [4:0] NO_DIGIT = 5'd16;

    typedef struct packed {
        t_phase              phase;
        t_radix              radix_sel;
        logic [ValueW-1:0]   accum;
        logic                digit_seen;
        logic                verdict_ok;
        t_mode               mode_l;
    } t_state;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              ok;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_SKIP,
        radix_sel:  RX_DEC,
        accum:      '0,
        digit_seen: 1'b0,
        verdict_ok: 1'b0,
        mode_l:     MODE_AUTO
    };

    function automatic logic is_term(logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) ||
               (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [ValueW-1:0] error_value(logic [ModeW-1:0] m);
        return (m == MODE_HEX) ? '0 : '1;
    endfunction

    function automatic logic [4:0] digit_of(t_radix rx, logic [7:0] c);
        logic [7:0] u;
        u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
        case (rx)
            RX_HEX: begin
                if (u >= CH_0 && u <= CH_9) return 5'(u - CH_0);
                if (u >= CH_UA && u <= CH_UF) return 5'(u - ALPHA_OFS);
                return NO_DIGIT;
            end
            RX_OCT: return (c >= CH_0 && c <= CH_7) ? 5'(c - CH_0) : NO_DIGIT;
            default: return (c >= CH_0 && c <= CH_9) ? 5'(c - CH_0) : NO_DIGIT;
        endcase
    endfunction

    function automatic t_state digit_step(t_state s, logic [7:0] c);
        t_state            n;
        logic [4:0]        d;
        logic [ValueW-1:0] scaled;
        logic              term_ok;
        n = s;
        d = digit_of(s.radix_sel, c);
        case (s.radix_sel)
            RX_HEX:  scaled = s.accum << 4;
            RX_OCT:  scaled = s.accum << 3;
            default: scaled = (s.accum << 3) + (s.accum << 1);
        endcase
        case (s.mode_l)
            MODE_DEC: term_ok = 1'b1;
            MODE_HEX: term_ok = (c == CH_DOT) || (c == CH_COLON) || is_term(c);
            default:  term_ok = is_term(c);
        endcase
        if (d != NO_DIGIT) begin
            n.accum      = scaled + ValueW'(d[3:0]);
            n.digit_seen = 1'b1;
        end else begin
            n.verdict_ok = s.digit_seen && term_ok;
            if (!(s.digit_seen && term_ok)) begin
                n.accum = error_value(s.mode_l);
            end
            n.phase = PH_DONE;
        end
        return n;
    endfunction

    function automatic t_state feed_byte(t_state s, logic [7:0] c, logic [ModeW-1:0] pmode);
        t_state n;
        t_mode  m;
        n = s;
        m = (pmode == MODE_DEC) ? MODE_DEC : ((pmode == MODE_HEX) ? MODE_HEX : MODE_AUTO);
        case (s.phase)
            PH_SKIP: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    n = s;
                end else if (c == CH_NUL) begin
                    n.verdict_ok = 1'b0;
                    n.accum      = error_value(pmode);
                    n.phase      = PH_DONE;
                end else begin
                    n.mode_l     = m;
                    n.accum      = '0;
                    n.digit_seen = 1'b0;
                    if (m == MODE_AUTO && c == CH_0) begin
                        n.digit_seen = 1'b1;
                        n.phase      = PH_ZERO;
                    end else begin
                        n.radix_sel = (m == MODE_HEX) ? RX_HEX : RX_DEC;
                        n.phase     = PH_DIGITS;
                        n           = digit_step(n, c);
                    end
                end
            end
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    n.radix_sel  = RX_HEX;
                    n.digit_seen = 1'b0;
                    n.phase      = PH_DIGITS;
                end else begin
                    n.radix_sel = RX_OCT;
                    n.phase     = PH_DIGITS;
                    n           = digit_step(n, c);
                end
            end
            PH_DIGITS: n = digit_step(s, c);
            default:   n = s;
        endcase
        return n;
    endfunction

endpackage

[sv/rpnp_core.sv]
// rpnp_core: per-string parse state and the one-byte update with end-of-string close
// depends on rpnp_pkg
`timescale 1ns / 1ps

module rpnp_core
    import rpnp_pkg::*;
#(
    parameter int unsigned P_MODE_W = ModeW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    input  logic [P_MODE_W-1:0] i_mode,
    output t_result             o_result
);

    t_state r_state;
    t_state n_state;
    t_state s_after;
    t_state s_closed;

    always_comb begin
        s_after  = feed_byte(r_state, i_ch, ModeW'(i_mode));
        s_closed = (s_after.phase == PH_DONE) ? s_after :
                   feed_byte(s_after, CH_NUL, ModeW'(i_mode));
        o_result.value = s_closed.accum;
        o_result.ok    = s_closed.verdict_ok;
        n_state = r_state;
        if (i_go) begin
            n_state = i_last ? STATE_RESET : s_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/radix_prefix_number_parser.sv]
// radix_prefix_number_parser: top level with input register, parse core and result register
// depends on rpnp_pkg and rpnp_core
`timescale 1ns / 1ps

// Parses one unsigned 32-bit number from a byte stream, one byte per transaction, and returns
// one result transaction (value, ok) for the byte flagged last. A byte is taken every cycle
// unless input stalls; the input register feeds the parse core, whose state update (one
// shift-add by the radix and the character compares) is combinational; the last byte's result
// is registered in the result register. Input stalls only when a finished result waits in the
// output register and the next registered byte ends another string. Write the mode register
// only while no string is in flight: 0 auto radix by prefix, 1 decimal, 2 hex, 3 as auto.

module radix_prefix_number_parser
    import rpnp_pkg::*;
#(
    parameter int unsigned P_MODE_W  = ModeW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [P_MODE_W-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ValueW-1:0]    o_value,
    output logic                 o_ok
);

    logic [P_MODE_W-1:0]  r_mode;
    logic                 r_in_valid;
    logic [7:0]           r_ch;
    logic                 r_last;
    logic                 r_out_valid;
    logic [ValueW-1:0]    r_value;
    logic                 r_ok;

    logic    s_out_free;
    logic    s_go;
    t_result s_result;

    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_go       = r_in_valid && (!r_last || s_out_free);
    assign o_in_ready = !r_in_valid || s_go;

    rpnp_core #(
        .P_MODE_W (P_MODE_W)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s_go),
        .i_ch     (r_ch),
        .i_last   (r_last),
        .i_mode   (r_mode),
        .o_result (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= P_MODE_W'(MODE_AUTO);
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && r_last) begin
            r_value <= s_result.value;
            r_ok    <= s_result.ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_ok        = r_ok;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && r_last) |=> o_out_valid)
        else $error("last byte did not produce a result");

    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_value == '0 || o_value == '1))
        else $error("failed parse without error value");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_last && o_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");
`endif

endmodule

[tb/sv/radix_prefix_number_parser_tb.sv]
// radix_prefix_number_parser_tb: self-checking bench for the number parser, with directed
// strings then random strings under every parse mode and random stalls on both channels
// depends on rpnp_pkg and radix_prefix_number_parser
`timescale 1ns / 1ps

module radix_prefix_number_parser_tb;
    import rpnp_pkg::*;

    // tracks the string being parsed and holds the numbers still owed by the block
    class number_book;
        logic [1:0]  mode;
        t_phase      phase;
        t_radix      radix;
        t_mode       locked_mode;
        logic [31:0] acc;
        logic        seen;
        logic        good;
        t_result     expected_numbers[$];
        int          failures;

        function new();
            mode = MODE_AUTO;
            failures = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_SKIP;
            radix = RX_DEC;
            acc = '0;
            seen = 1'b0;
            good = 1'b0;
            locked_mode = MODE_AUTO;
        endfunction

        function logic [31:0] fault_value(logic [1:0] m);
            return (m == MODE_HEX) ? 32'd0 : 32'hFFFF_FFFF;
        endfunction

        function logic ends_number(logic [7:0] c);
            return c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
        endfunction

        function logic [4:0] digit_weight(logic [7:0] c);
            logic [7:0] u;
            u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
            if (radix == RX_HEX) begin
                if (u >= CH_0 && u <= CH_9) return 5'(u - CH_0);
                if (u >= CH_UA && u <= CH_UF) return 5'(u - CH_UA + 8'd10);
                return NO_DIGIT;
            end
            if (radix == RX_OCT) return (c >= CH_0 && c <= CH_7) ? 5'(c - CH_0) : NO_DIGIT;
            return (c >= CH_0 && c <= CH_9) ? 5'(c - CH_0) : NO_DIGIT;
        endfunction

        function void take_digit(logic [7:0] c);
            logic [4:0] d;
            logic       term_ok;
            int         base;
            d = digit_weight(c);
            if (d != NO_DIGIT) begin
                base = (radix == RX_HEX) ? 16 : ((radix == RX_OCT) ? 8 : 10);
                acc = acc * base + {27'd0, d};
                seen = 1'b1;
                return;
            end
            case (locked_mode)
                MODE_DEC: term_ok = 1'b1;
                MODE_HEX: term_ok = c == CH_DOT || c == CH_COLON || ends_number(c);
                default:  term_ok = ends_number(c);
            endcase
            good = seen && term_ok;
            if (!good) acc = fault_value(locked_mode);
            phase = PH_DONE;
        endfunction

        function void scan_byte(logic [7:0] c);
            case (phase)
                PH_SKIP: begin
                    if (c == CH_SPACE || c == CH_TAB) return;
                    if (c == CH_NUL) begin
                        good = 1'b0;
                        acc = fault_value(mode);
                        phase = PH_DONE;
                        return;
                    end
                    locked_mode = (mode == MODE_DEC || mode == MODE_HEX) ? t_mode'(mode) : MODE_AUTO;
                    acc = '0;
                    seen = 1'b0;
                    if (locked_mode == MODE_AUTO && c == CH_0) begin
                        seen = 1'b1;
                        phase = PH_ZERO;
                        return;
                    end
                    radix = (locked_mode == MODE_HEX) ? RX_HEX : RX_DEC;
                    phase = PH_DIGITS;
                    take_digit(c);
                end
                PH_ZERO: begin
                    if (c == CH_LX || c == CH_UX) begin
                        radix = RX_HEX;
                        seen = 1'b0;
                        phase = PH_DIGITS;
                        return;
                    end
                    radix = RX_OCT;
                    phase = PH_DIGITS;
                    take_digit(c);
                end
                PH_DIGITS: take_digit(c);
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic l);
            t_result r;
            scan_byte(c);
            if (!l) return;
            if (phase != PH_DONE) scan_byte(CH_NUL);
            r.value = acc;
            r.ok = good;
            expected_numbers.push_back(r);
            restart();
        endfunction

        function void check_result(logic [31:0] v, logic k);
            t_result e;
            if (expected_numbers.size() == 0) begin
                $error("unexpected result transaction: value %h ok %b", v, k);
                failures++;
                return;
            end
            e = expected_numbers.pop_front();
            if (v !== e.value) begin
                $error("value: expected %h, actual %h", e.value, v);
                failures++;
            end
            if (k !== e.ok) begin
                $error("ok: expected %b, actual %b", e.ok, k);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_ch = '0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_value;
    logic        o_ok;

    number_book  book;
    logic [7:0]  text[$];
    logic        quiet = 1'b0;
    int          bytes_sent = 0;
    int          hold_left = 0;

    radix_prefix_number_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_ok        (o_ok)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] end_char(int k);
        case (k)
            0:       return CH_NUL;
            1:       return CH_SPACE;
            2:       return CH_TAB;
            3:       return CH_LF;
            4:       return CH_CR;
            5:       return CH_DOT;
            default: return CH_COLON;
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] dec_char(int lo);
        return 8'(CH_0 + $urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(CH_0 + v);
        return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10);
    endfunction

    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 3) == 0) return end_char($urandom_range(0, 6));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int digit_count();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 4);
    endfunction

    // output side: check each result transaction and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            book.check_result(o_value, o_ok);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left = pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= c;
        i_last <= l;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        book.note_byte(c, l);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
        text.delete();
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_in_valid <= 1'b0;
        while (book.expected_numbers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.mode = m;
    endtask

    task automatic make_string(input logic [1:0] m);
        int r;
        int n;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            repeat ($urandom_range(1, 3)) text.push_back(blank_char());
        end else if (r < 5) begin
            repeat ($urandom_range(1, 6)) text.push_back(noise_char());
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) text.push_back(blank_char());
            end
            n = digit_count();
            if ((m == MODE_DEC || m == MODE_HEX) && $urandom_range(0, 3) != 0) begin
                repeat (n) text.push_back(m == MODE_HEX ? hex_char() : dec_char(0));
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        text.push_back(CH_0);
                        text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                        if ($urandom_range(0, 5) == 0) n = 0;
                        repeat (n) text.push_back(hex_char());
                    end
                    1: begin
                        text.push_back(CH_0);
                        repeat (n - 1) text.push_back(8'(CH_0 + $urandom_range(0, 7)));
                    end
                    default: begin
                        text.push_back(dec_char(1));
                        repeat (n - 1) text.push_back(dec_char(0));
                    end
                endcase
            end
            r = $urandom_range(0, 9);
            if (r < 7) text.push_back(end_char(r));
            else if (r == 7) text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 2)) text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int         phase_no;
        logic [1:0] m;
        book = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_AUTO);
        push_str(" 0x");
        send_text();
        push_str("0");
        send_text();
        push_str("09");
        send_text();
        push_str("\t ");
        send_text();
        text.push_back(CH_NUL);
        send_text();
        push_str("17");
        text.push_back(8'hFF);
        send_text();
        push_str("0XA:");
        send_text();
        write_mode(MODE_DEC);
        push_str("9z");
        send_text();
        write_mode(MODE_HEX);
        push_str("fF.");
        send_text();
        push_str("g");
        send_text();
        push_str("7");
        text.push_back(CH_NUL);
        push_str("x");
        send_text();

        phase_no = 0;
        while (bytes_sent < 1225) begin
            m = (phase_no < 4) ? 2'(phase_no + 3) : 2'($urandom_range(0, 3));
            quiet = ($urandom_range(0, 3) == 0);
            write_mode(m);
            repeat ($urandom_range(5, 25)) begin
                make_string(m);
                send_text();
            end
            phase_no++;
        end
        i_in_valid <= 1'b0;

        while (book.expected_numbers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (book.failures == 0) begin
            $display("radix_prefix_number_parser: match");
        end else begin
            $display("radix_prefix_number_parser: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("radix_prefix_number_parser: mismatch");
        $finish;
    end

endmodule

[filelist.f]
sv/rpnp_pkg.sv
sv/rpnp_core.sv
sv/radix_prefix_number_parser.sv
tb/sv/radix_prefix_number_parser_tb.sv
